>>> rtl/core/jkve_pkg.sv
// Package for the JSON key/value extractor: phase and mode codes, status codes,
// literal helpers and register index constants. No dependencies.
`default_nettype none
package jkve_pkg;

    localparam int KeyMaxDefault   = 40;
    localparam int PosBitsDefault  = 16;
    localparam int KeyWords        = 5;
    localparam int CfgIndexBits    = 3;
    localparam int CfgDataBits     = 64;

    typedef enum logic [2:0] {
        PH_SEARCH, PH_SKIP, PH_BOOL, PH_UINT, PH_RAW, PH_STRING, PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        MODE_BOOL = 2'd0, MODE_UINT = 2'd1, MODE_RAW = 2'd2, MODE_STRING = 2'd3
    } mode_t;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
    localparam logic [1:0] ST_BAD_VALUE  = 2'd2;
    localparam logic [1:0] ST_UNBALANCED = 2'd3;

    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_KEY_LEN   = 3'd1;
    localparam logic [2:0] REG_CAPACITY  = 3'd2;
    localparam logic [2:0] REG_KEY_WORD0 = 3'd3;

    localparam logic [30:0] SAT_MAX = 31'h7fff_ffff;

    // Expected literal character for bool parsing.
    function automatic logic [7:0] lit_char(input logic is_false, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (is_false) begin
            unique case (idx)
                3'd0: c = "f";
                3'd1: c = "a";
                3'd2: c = "l";
                3'd3: c = "s";
                3'd4: c = "e";
                default: c = 8'h00;
            endcase
        end else begin
            unique case (idx)
                3'd0: c = "t";
                3'd1: c = "r";
                3'd2: c = "u";
                3'd3: c = "e";
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

    typedef struct packed {
        logic        kind;
        logic [7:0]  char_byte;
        logic [1:0]  status;
        logic [31:0] value;
        logic [15:0] span_offset;
        logic [15:0] span_length;
        logic        last;
    } result_t;

endpackage
`default_nettype wire

>>> rtl/core/jkve_matcher.sv
// Key pattern matcher: compares the byte window against quote, key, quote, colon.
// Depends on jkve_pkg.
`default_nettype none
module jkve_matcher #(
    parameter int KEY_MAX = jkve_pkg::KeyMaxDefault
) (
    input  wire logic [(KEY_MAX+3)*8-1:0]            window,
    input  wire logic [5:0]                          key_length,
    input  wire logic [jkve_pkg::KeyWords*64-1:0]    key_bytes,
    output logic                                     match
);
    import jkve_pkg::*;

    localparam int WinDepth = KEY_MAX + 3;
    localparam int KeyAvail = KeyWords * 8;

    // window byte k is window[8k+7:8k], k = 0 newest.
    // Per length, pattern byte j sits at window index len+2-j.
    always_comb begin
        logic [WinDepth-1:0] ok;
        logic [7:0] want;
        logic [7:0] got;
        match = 1'b0;
        for (int len = 0; len <= KEY_MAX; len++) begin
            ok = '0;
            for (int j = 0; j < WinDepth; j++) begin
                want = 8'h00;
                if (j == 0 || j == len + 1) want = 8'h22;
                else if (j == len + 2)      want = 8'h3a;
                else if (j - 1 < KeyAvail)  want = key_bytes[(j-1)*8 +: 8];
                got = window[(len+2-j >= 0 ? len+2-j : 0)*8 +: 8];
                ok[j] = (j > len + 2) || (got == want);
            end
            if (key_length == 6'(len) && (&ok)) match = 1'b1;
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/json_key_value_extractor_top.sv
// Top level of the JSON key/value extractor: config registers, document state,
// result register with skid buffer. Depends on jkve_pkg and jkve_matcher.
//
//  Channel | Dir | Ports                       | Payload
//  s_      | in  | s_tvalid s_tready s_tdata s_tlast | doc_byte, doc_last
//  m_      | out | m_tvalid m_tready m_tdata m_tuser m_tlast | result fields
//  cfg     | in  | cfg_we cfg_index cfg_data   | registers by index
//
// One document byte per cycle. Each byte is processed in the accept cycle and
// yields up to two results (a copied char then a final answer), which go into a
// two-entry output queue; s_tready is low while the queue holds two results, or
// holds one and m_tready is low, so m_tready reaches s_tready through one gate.
// Reset (aresetn low, synchronous) clears config, document state and queue.
// A byte that yields two results stalls the next byte while both results are queued.
`default_nettype none
module json_key_value_extractor_top #(
    parameter int KEY_MAX  = jkve_pkg::KeyMaxDefault,
    parameter int POS_BITS = jkve_pkg::PosBitsDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // doc_byte
    input  wire logic        s_tlast,   // doc_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // char_byte, status, value, span_offset, span_length
    output logic             m_tuser,   // kind
    output logic             m_tlast,   // last
    input  wire logic        cfg_we,
    input  wire logic [jkve_pkg::CfgIndexBits-1:0] cfg_index,
    input  wire logic [jkve_pkg::CfgDataBits-1:0]  cfg_data
);
    import jkve_pkg::*;

    localparam int WinDepth = KEY_MAX + 3;

    // Configuration registers
    logic [1:0]  mode_reg;
    logic [5:0]  key_len_reg;
    logic [8:0]  cap_reg;
    logic [KeyWords*64-1:0] key_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= '0; key_len_reg <= '0; cap_reg <= 9'd1; key_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == REG_MODE) mode_reg <= cfg_data[1:0];
            else if (cfg_index == REG_KEY_LEN) key_len_reg <= cfg_data[5:0];
            else if (cfg_index == REG_CAPACITY) cap_reg <= cfg_data[8:0];
            else key_reg[(32'(cfg_index) - 32'(REG_KEY_WORD0)) * 64 +: 64] <= cfg_data;
        end
    end

    // Document state
    logic [WinDepth*8-1:0] win_reg, win_next;
    phase_t                phase_reg, phase_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next, vstart_reg, vstart_next;
    logic [30:0]           acc_reg, acc_next;
    logic [1:0]            sign_reg, sign_next;
    logic                  digit_reg, digit_next;
    logic [2:0]            lit_reg, lit_next;
    logic                  litf_reg, litf_next;
    logic [15:0]           depth_reg, depth_next;
    logic                  sq_reg, sq_next;
    logic                  instr_reg, instr_next;
    logic                  esc_reg, esc_next;
    logic [8:0]            cnt_reg, cnt_next;

    // Output queue, two entries
    result_t q_reg [2];
    result_t q_next [2];
    logic [1:0] qn_reg, qn_next;
    result_t r0, r1;
    logic [1:0] nres;

    logic match;
    jkve_matcher #(.KEY_MAX(KEY_MAX)) u_match (
        .window({win_reg[(WinDepth-1)*8-1:0], s_tdata}),
        .key_length(key_len_reg), .key_bytes(key_reg), .match(match));

    wire accept = s_tvalid && s_tready;
    wire [8:0] cap_eff = (cap_reg == 9'd0) ? 9'd1 : cap_reg;

    always_comb begin
        logic [7:0] c;
        logic is_digit;
        logic [34:0] prod;
        logic answered;
        logic [1:0] ast;
        logic [31:0] aval;
        logic [15:0] aoff, alen;
        logic [POS_BITS-1:0] diff;
        logic [7:0] opn, cls;
        result_t ch;
        c = s_tdata;
        is_digit = (c >= "0") && (c <= "9");
        prod = 35'(acc_reg) * 35'd10 + 35'(c - 8'h30);
        answered = 1'b0; ast = ST_OK; aval = '0; aoff = '0; alen = '0;
        diff = pos_reg - vstart_reg;
        opn = sq_reg ? "[" : "{";
        cls = sq_reg ? "]" : "}";
        ch = '0;
        nres = 2'd0;
        win_next = win_reg; phase_next = phase_reg; vstart_next = vstart_reg;
        acc_next = acc_reg; sign_next = sign_reg; digit_next = digit_reg;
        lit_next = lit_reg; litf_next = litf_reg; depth_next = depth_reg;
        sq_next = sq_reg; instr_next = instr_reg; esc_next = esc_reg;
        cnt_next = cnt_reg;
        pos_next = pos_reg + 1'b1;
        if (phase_reg != PH_DONE && c != 8'h00) begin
            unique case (phase_reg)
                PH_SEARCH: begin
                    win_next = {win_reg[(WinDepth-1)*8-1:0], c};
                    if (match) phase_next = PH_SKIP;
                end
                PH_SKIP: begin
                    if (c == 8'h20 || c == 8'h09) begin
                    end else if (mode_reg == MODE_UINT &&
                                 (c == 8'h0a || c == 8'h0d || c == 8'h0b || c == 8'h0c)) begin
                    end else begin
                        unique case (mode_t'(mode_reg))
                            MODE_BOOL: begin
                                if (c == "t" || c == "f") begin
                                    litf_next = (c == "f"); lit_next = 3'd1;
                                    phase_next = PH_BOOL;
                                end else begin
                                    answered = 1'b1; ast = ST_BAD_VALUE;
                                end
                            end
                            MODE_UINT: begin
                                acc_next = '0; digit_next = 1'b0; sign_next = 2'd0;
                                phase_next = PH_UINT;
                                if (c == "+") sign_next = 2'd1;
                                else if (c == "-") sign_next = 2'd2;
                                else if (is_digit) begin
                                    acc_next = 31'(c - 8'h30); digit_next = 1'b1;
                                end else begin
                                    answered = 1'b1; ast = ST_BAD_VALUE;
                                end
                            end
                            MODE_RAW: begin
                                if (c == "{" || c == "[") begin
                                    sq_next = (c == "["); vstart_next = pos_reg;
                                    depth_next = 16'd1; instr_next = 1'b0;
                                    esc_next = 1'b0; phase_next = PH_RAW;
                                end else begin
                                    answered = 1'b1; ast = ST_BAD_VALUE;
                                end
                            end
                            MODE_STRING: begin
                                if (c != 8'h22) begin
                                    answered = 1'b1; ast = ST_BAD_VALUE;
                                end else begin
                                    cnt_next = '0;
                                    if (cap_eff <= 9'd1) answered = 1'b1;
                                    else phase_next = PH_STRING;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                PH_BOOL: begin
                    if (c != lit_char(litf_reg, lit_reg)) begin
                        answered = 1'b1; ast = ST_BAD_VALUE;
                    end else begin
                        lit_next = lit_reg + 3'd1;
                        if (lit_next == (litf_reg ? 3'd5 : 3'd4)) begin
                            answered = 1'b1; aval = {31'd0, !litf_reg};
                        end
                    end
                end
                PH_UINT: begin
                    if (is_digit) begin
                        acc_next = (prod > 35'(SAT_MAX)) ? SAT_MAX : prod[30:0];
                        digit_next = 1'b1;
                    end else begin
                        answered = 1'b1;
                        if (!digit_reg || (sign_reg == 2'd2 && acc_reg != '0))
                            ast = ST_BAD_VALUE;
                        else aval = {1'b0, acc_reg};
                    end
                end
                PH_RAW: begin
                    if (esc_reg) esc_next = 1'b0;
                    else if (instr_reg) begin
                        if (c == 8'h5c) esc_next = 1'b1;
                        else if (c == 8'h22) instr_next = 1'b0;
                    end else if (c == 8'h22) instr_next = 1'b1;
                    else if (c == opn) depth_next = depth_reg + 16'd1;
                    else if (c == cls) begin
                        depth_next = depth_reg - 16'd1;
                        if (depth_next == '0) begin
                            answered = 1'b1;
                            aoff = 16'(vstart_reg);
                            // length is the wrapped difference plus one, cut to 16 bits
                            alen = 16'({1'b0, diff} + (POS_BITS+1)'(1));
                        end
                    end
                end
                PH_STRING: begin
                    if (c == 8'h22) answered = 1'b1;
                    else begin
                        ch.char_byte = c; nres = 2'd1;
                        cnt_next = cnt_reg + 9'd1;
                        if (10'(cnt_next) + 10'd1 >= 10'(cap_eff)) answered = 1'b1;
                    end
                end
                default: ;
            endcase
            // End of document without a decision
            if (s_tlast && !answered) begin
                answered = 1'b1;
                unique case (phase_next)
                    PH_SEARCH: ast = ST_NOT_FOUND;
                    PH_UINT: begin
                        if (!digit_next || (sign_next == 2'd2 && acc_next != '0))
                            ast = ST_BAD_VALUE;
                        else aval = {1'b0, acc_next};
                    end
                    PH_RAW: ast = ST_UNBALANCED;
                    PH_STRING: ast = ST_OK;
                    default: ast = ST_BAD_VALUE;
                endcase
            end
        end else if (phase_reg != PH_DONE) begin
            // Zero byte ends the text
            answered = 1'b1;
            unique case (phase_reg)
                PH_SEARCH: ast = ST_NOT_FOUND;
                PH_UINT: begin
                    if (!digit_reg || (sign_reg == 2'd2 && acc_reg != '0))
                        ast = ST_BAD_VALUE;
                    else aval = {1'b0, acc_reg};
                end
                PH_RAW: ast = ST_UNBALANCED;
                PH_STRING: ast = ST_OK;
                default: ast = ST_BAD_VALUE;
            endcase
        end
        if (answered) phase_next = PH_DONE;
        r0 = ch; r1 = '0;
        if (answered) begin
            r1.kind = 1'b1; r1.status = ast; r1.value = aval;
            r1.span_offset = aoff; r1.span_length = alen; r1.last = 1'b1;
            if (nres == 2'd1) nres = 2'd2;
            else begin r0 = r1; nres = 2'd1; end
        end
    end

    // Accept only while the queue can absorb two results this cycle.
    wire pop = m_tvalid && m_tready;
    assign s_tready = (qn_reg == 2'd0) || (qn_reg == 2'd1 && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_tlast)) begin
            win_reg <= '0; phase_reg <= PH_SEARCH; vstart_reg <= '0; acc_reg <= '0;
            sign_reg <= '0; digit_reg <= 1'b0; lit_reg <= '0; litf_reg <= 1'b0;
            depth_reg <= '0; sq_reg <= 1'b0; instr_reg <= 1'b0; esc_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (accept) begin
            win_reg <= win_next; phase_reg <= phase_next; vstart_reg <= vstart_next;
            acc_reg <= acc_next; sign_reg <= sign_next; digit_reg <= digit_next;
            lit_reg <= lit_next; litf_reg <= litf_next; depth_reg <= depth_next;
            sq_reg <= sq_next; instr_reg <= instr_next; esc_reg <= esc_next;
            cnt_reg <= cnt_next;
        end
        // position restarts with each document
        if (!aresetn || (accept && s_tlast)) pos_reg <= '0;
        else if (accept) pos_reg <= pos_next;
    end

    // Queue: entry 0 is the head. Advance on pop, then append new results.
    always_comb begin
        logic [1:0] base;
        base = qn_reg - {1'b0, pop};
        q_next[0] = pop ? q_reg[1] : q_reg[0];
        q_next[1] = q_reg[1];
        if (accept && nres != 2'd0) begin
            if (base == 2'd0) begin
                q_next[0] = r0; q_next[1] = r1;
            end else q_next[1] = r0;
        end
        qn_next = base + (accept ? nres : 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qn_reg <= '0;
        end else begin
            q_reg[0] <= q_next[0];
            q_reg[1] <= q_next[1];
            qn_reg   <= qn_next;
        end
    end

    assign m_tvalid = (qn_reg != 2'd0);
    assign m_tuser  = q_reg[0].kind;
    assign m_tlast  = q_reg[0].last;
    assign m_tdata  = {6'd0, q_reg[0].span_length, q_reg[0].span_offset, q_reg[0].value,
                       q_reg[0].status, q_reg[0].char_byte};

    // Queue never overfills.
    assert property (@(posedge aclk) disable iff (!aresetn) qn_reg != 2'd3)
        else $error("result queue overflow");
    // A copied character is never flagged last.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> !m_tlast) else $error("char marked last");
    // After a document end the phase is back to searching.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> phase_reg == PH_SEARCH) else $error("doc state kept");

endmodule
`default_nettype wire
